// ===== hw/rtl/csct_pkg.sv =====
// ----------------------------------------------------------------------------
// Convex shape collision test package
// Opcodes, normalizer request/response types and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csct_pkg;

    localparam int COORD_W = 32;
    localparam int VTX_W   = 2 * COORD_W;

    localparam logic [1:0] OP_VERT_A = 2'd0;
    localparam logic [1:0] OP_VERT_B = 2'd1;
    localparam logic [1:0] OP_DESC_A = 2'd2;
    localparam logic [1:0] OP_DESC_B = 2'd3;

    typedef struct packed {
        logic               start;
        logic               raw;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } norm_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic        [31:0] len;
    } norm_rsp_t;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csct_vmem.sv =====
// ----------------------------------------------------------------------------
// Vertex memory
// One write port, one synchronous read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module csct_vmem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [csct_pkg::VTX_W-1:0] wdata,
    input  wire logic [AW-1:0]              raddr,
    output logic      [csct_pkg::VTX_W-1:0] rdata
);

    logic [csct_pkg::VTX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/csct_norm.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a vector to a Q1.14 unit vector with an iterative square root and
// a restoring divider. Raw mode returns only floor(sqrt(x*x + y*y)).
// ----------------------------------------------------------------------------
`default_nettype none

module csct_norm (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire csct_pkg::norm_req_t req,
    output csct_pkg::norm_rsp_t      rsp
);

    typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SUM, N_SQRT, N_DIV} nstate_t;

    nstate_t            state_reg;
    logic               raw_reg;
    logic               sx_reg;
    logic               sy_reg;
    logic        [31:0] mx_reg;
    logic        [31:0] my_reg;
    logic        [63:0] sqx_reg;
    logic        [63:0] sqy_reg;
    logic        [63:0] rad_reg;
    logic        [31:0] root_reg;
    logic        [33:0] rem_reg;
    logic        [4:0]  step_reg;
    logic        [45:0] dvs_reg;
    logic        [45:0] remx_reg;
    logic        [45:0] remy_reg;
    logic        [14:0] qx_reg;
    logic        [14:0] qy_reg;
    logic               done_reg;
    logic signed [15:0] ux_reg;
    logic signed [15:0] uy_reg;
    logic        [31:0] len_reg;

    logic [35:0] rem2;
    logic [35:0] trial;
    logic [35:0] sq_diff;
    logic        sq_ge;
    logic [31:0] root_next;
    logic [33:0] rem_next;
    logic        gex;
    logic        gey;
    logic [14:0] qx_next;
    logic [14:0] qy_next;

    always_comb
    begin
        rem2      = {rem_reg, rad_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        sq_ge     = rem2 >= trial;
        sq_diff   = rem2 - trial;
        root_next = {root_reg[30:0], sq_ge};
        rem_next  = sq_ge ? sq_diff[33:0] : rem2[33:0];
        gex       = remx_reg >= dvs_reg;
        gey       = remy_reg >= dvs_reg;
        qx_next   = {qx_reg[13:0], gex};
        qy_next   = {qy_reg[13:0], gey};
    end

    assign rsp.done = done_reg;
    assign rsp.ux   = ux_reg;
    assign rsp.uy   = uy_reg;
    assign rsp.len  = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            raw_reg   <= 1'b0;
            sx_reg    <= 1'b0;
            sy_reg    <= 1'b0;
            mx_reg    <= '0;
            my_reg    <= '0;
            sqx_reg   <= '0;
            sqy_reg   <= '0;
            rad_reg   <= '0;
            root_reg  <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
            dvs_reg   <= '0;
            remx_reg  <= '0;
            remy_reg  <= '0;
            qx_reg    <= '0;
            qy_reg    <= '0;
            done_reg  <= 1'b0;
            ux_reg    <= '0;
            uy_reg    <= '0;
            len_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (req.start)
                    begin
                        raw_reg   <= req.raw;
                        sx_reg    <= req.dx[32];
                        sy_reg    <= req.dy[32];
                        mx_reg    <= csct_pkg::mag33(req.dx);
                        my_reg    <= csct_pkg::mag33(req.dy);
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    // Halve both until they fit in 30 bits, so the square sum stays small.
                    if (!raw_reg && (mx_reg[31:30] != 2'b00 || my_reg[31:30] != 2'b00))
                    begin
                        mx_reg <= mx_reg >> 1;
                        my_reg <= my_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    sqx_reg   <= mx_reg * mx_reg;
                    sqy_reg   <= my_reg * my_reg;
                    state_reg <= N_SUM;
                end
                N_SUM:
                begin
                    rad_reg   <= sqx_reg + sqy_reg;
                    root_reg  <= '0;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= N_SQRT;
                end
                N_SQRT:
                begin
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                    root_reg <= root_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        len_reg  <= root_next;
                        step_reg <= '0;
                        if (raw_reg)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else if (root_next == '0)
                        begin
                            ux_reg    <= '0;
                            uy_reg    <= '0;
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            // Rounded quotient: (m * 16384 + len / 2) / len.
                            dvs_reg   <= {1'b0, root_next[30:0], 14'b0};
                            remx_reg  <= {2'b00, mx_reg[29:0], 14'b0} +
                                         {15'b0, root_next[31:1]};
                            remy_reg  <= {2'b00, my_reg[29:0], 14'b0} +
                                         {15'b0, root_next[31:1]};
                            qx_reg    <= '0;
                            qy_reg    <= '0;
                            state_reg <= N_DIV;
                        end
                    end
                end
                N_DIV:
                begin
                    if (gex)
                    begin
                        remx_reg <= remx_reg - dvs_reg;
                    end
                    if (gey)
                    begin
                        remy_reg <= remy_reg - dvs_reg;
                    end
                    qx_reg   <= qx_next;
                    qy_reg   <= qy_next;
                    dvs_reg  <= dvs_reg >> 1;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd14)
                    begin
                        ux_reg    <= sx_reg ? -$signed({1'b0, qx_next}) : $signed({1'b0, qx_next});
                        uy_reg    <= sy_reg ? -$signed({1'b0, qy_next}) : $signed({1'b0, qy_next});
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/convex_shape_collision_test_core.sv =====
// ----------------------------------------------------------------------------
// Convex shape collision test core
// Loads two convex shapes and runs a separating axis test between them,
// reporting hit, unit normal from A toward B and penetration depth.
// ----------------------------------------------------------------------------
//  channel  | ports                                       | handshake
//  request  | opcode coord_x coord_y radius is_circle     | start, taken when !busy
//  result   | hit normal_x normal_y penetration_depth     | done, one-cycle strobe
//
//  Vertex and descriptor A requests leave the core idle. A test request keeps busy
//  high while, for each tested edge axis, the normalizer runs its iterative root
//  (32 steps) and divider (15 steps) and the vertex memory read loop walks the
//  L vertices (L = larger polygon vertex count), plus a nearest-vertex search over
//  the polygon vertices when one shape is a circle.
//  Reset clears the counts and descriptors A and B; the vertex memories are not cleared.
//  The result cannot be stalled; the core returns to idle as it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_shape_collision_test_core #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic [30:0]        radius,
    input  wire logic               is_circle,
    output logic                    busy,
    output logic                    done,
    output logic                    hit,
    output logic signed [15:0]      normal_x,
    output logic signed [15:0]      normal_y,
    output logic [30:0]             penetration_depth
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int PW = 50;
    localparam int BW = 52;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_EDGE, S_EW0, S_EW1, S_EW2, S_NWAIT,
        S_PADDR, S_PWAIT, S_PMUL, S_PACC, S_EVAL, S_ADV,
        S_NADDR, S_NWT, S_NDIFF, S_NSQ, S_NCMP, S_NAXIS,
        S_FIN, S_FLIP, S_CC0, S_CC1, S_CC2, S_CC3, S_CC4, S_MISS
    } state_t;

    typedef enum logic [1:0] {P_EDGE_A, P_EDGE_B, P_NEAR} phase_t;

    state_t             state_reg;
    phase_t             phase_reg;
    logic [CW-1:0]      cnt_a_reg;
    logic [CW-1:0]      cnt_b_reg;
    logic signed [31:0] ca_x_reg;
    logic signed [31:0] ca_y_reg;
    logic [30:0]        ra_reg;
    logic               circ_a_reg;
    logic signed [31:0] cb_x_reg;
    logic signed [31:0] cb_y_reg;
    logic [30:0]        rb_reg;
    logic               circ_b_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pidx_reg;
    logic [AW-1:0]      addr_reg;
    logic signed [31:0] e0x_reg;
    logic signed [31:0] e0y_reg;
    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [47:0] pxa_reg;
    logic signed [47:0] pya_reg;
    logic signed [47:0] pxb_reg;
    logic signed [47:0] pyb_reg;
    logic signed [PW-1:0] loa_reg;
    logic signed [PW-1:0] hia_reg;
    logic signed [PW-1:0] lob_reg;
    logic signed [PW-1:0] hib_reg;
    logic [BW-1:0]      best_reg;
    logic signed [15:0] bnx_reg;
    logic signed [15:0] bny_reg;
    logic               tested_reg;
    logic [63:0]        bd_reg;
    logic signed [31:0] bvx_reg;
    logic signed [31:0] bvy_reg;
    logic signed [31:0] curx_reg;
    logic signed [31:0] cury_reg;
    logic [31:0]        nmx_reg;
    logic [31:0]        nmy_reg;
    logic [63:0]        s1_reg;
    logic [63:0]        s2_reg;
    logic [63:0]        rr_reg;
    logic [31:0]        rsum_reg;
    logic signed [48:0] dpx_reg;
    logic signed [48:0] dpy_reg;
    logic               done_reg;
    logic               hit_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic [30:0]        depth_reg;

    logic [csct_pkg::VTX_W-1:0] rda;
    logic [csct_pkg::VTX_W-1:0] rdb;
    logic                       accept;
    logic                       we_a;
    logic                       we_b;
    logic                       use_b;
    logic [CW-1:0]              n_sel;
    logic [CW-1:0]              idx_inc;
    logic [CW-1:0]              pidx_inc;
    logic [CW-1:0]              edge_j;
    logic [CW-1:0]              len_a;
    logic [CW-1:0]              len_b;
    logic [CW-1:0]              plen;
    logic signed [31:0]         pdx;
    logic signed [31:0]         pdy;
    logic signed [31:0]         cc_x;
    logic signed [31:0]         cc_y;
    logic signed [31:0]         xa_src;
    logic signed [31:0]         ya_src;
    logic signed [31:0]         xb_src;
    logic signed [31:0]         yb_src;
    logic signed [PW-1:0]       p_a;
    logic signed [PW-1:0]       p_b;
    logic signed [PW-1:0]       rr_a;
    logic signed [PW-1:0]       rr_b;
    logic signed [PW:0]         d1;
    logic signed [PW:0]         d2;
    logic signed [PW:0]         dmin;
    logic [BW-1:0]              dmin_u;
    logic                       sep;
    logic signed [32:0]         dcx;
    logic signed [32:0]         dcy;
    logic signed [32:0]         ndx;
    logic signed [32:0]         ndy;
    logic [64:0]                ns65;
    logic [63:0]                ns;
    logic                       cc_hit;
    logic [49:0]                dot;
    logic [31:0]                cc_dd;
    logic [30:0]                poly_depth;
    csct_pkg::norm_req_t        nreq;
    csct_pkg::norm_rsp_t        nrsp;

    csct_vmem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vmem_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata ({coord_x, coord_y}),
        .raddr (addr_reg),
        .rdata (rda)
    );

    csct_vmem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vmem_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata ({coord_x, coord_y}),
        .raddr (addr_reg),
        .rdata (rdb)
    );

    csct_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .rsp   (nrsp)
    );

    always_comb
    begin
        busy   = state_reg != S_IDLE;
        accept = start && !busy;
        we_a   = accept && opcode == csct_pkg::OP_VERT_A && cnt_a_reg < CW'(MAX_VERTICES);
        we_b   = accept && opcode == csct_pkg::OP_VERT_B && cnt_b_reg < CW'(MAX_VERTICES);

        // The polygon being walked: edges of B, or the polygon paired with a circle.
        use_b    = (phase_reg == P_EDGE_B) || (phase_reg == P_NEAR && circ_a_reg);
        n_sel    = use_b ? cnt_b_reg : cnt_a_reg;
        idx_inc  = idx_reg + CW'(1);
        pidx_inc = pidx_reg + CW'(1);
        edge_j   = (idx_inc == n_sel) ? '0 : idx_inc;
        len_a    = circ_a_reg ? '0 : cnt_a_reg;
        len_b    = circ_b_reg ? '0 : cnt_b_reg;
        plen     = (len_a > len_b) ? len_a : len_b;

        pdx  = use_b ? $signed(rdb[63:32]) : $signed(rda[63:32]);
        pdy  = use_b ? $signed(rdb[31:0])  : $signed(rda[31:0]);
        cc_x = circ_a_reg ? ca_x_reg : cb_x_reg;
        cc_y = circ_a_reg ? ca_y_reg : cb_y_reg;

        xa_src = circ_a_reg ? ca_x_reg : $signed(rda[63:32]);
        ya_src = circ_a_reg ? ca_y_reg : $signed(rda[31:0]);
        xb_src = circ_b_reg ? cb_x_reg : $signed(rdb[63:32]);
        yb_src = circ_b_reg ? cb_y_reg : $signed(rdb[31:0]);

        p_a  = {{2{pxa_reg[47]}}, pxa_reg} + {{2{pya_reg[47]}}, pya_reg};
        p_b  = {{2{pxb_reg[47]}}, pxb_reg} + {{2{pyb_reg[47]}}, pyb_reg};
        rr_a = {5'b0, ra_reg, 14'b0};
        rr_b = {5'b0, rb_reg, 14'b0};

        sep    = (loa_reg >= hib_reg) || (lob_reg >= hia_reg);
        d1     = {hib_reg[PW-1], hib_reg} - {loa_reg[PW-1], loa_reg};
        d2     = {hia_reg[PW-1], hia_reg} - {lob_reg[PW-1], lob_reg};
        dmin   = (d2 < d1) ? d2 : d1;
        dmin_u = {1'b0, dmin};

        dcx = {cb_x_reg[31], cb_x_reg} - {ca_x_reg[31], ca_x_reg};
        dcy = {cb_y_reg[31], cb_y_reg} - {ca_y_reg[31], ca_y_reg};

        ns65   = {1'b0, s1_reg} + {1'b0, s2_reg};
        ns     = ns65[64] ? '1 : ns65[63:0];
        cc_hit = !ns65[64] && (ns65[63:0] < rr_reg);

        dot        = {dpx_reg[48], dpx_reg} + {dpy_reg[48], dpy_reg};
        cc_dd      = rsum_reg - nrsp.len;
        poly_depth = (best_reg[BW-1:45] != '0) ? 31'h7FFF_FFFF : best_reg[44:14];

        case (state_reg)
            S_EW2:
            begin
                ndx = {e0y_reg[31], e0y_reg} - {pdy[31], pdy};
                ndy = {pdx[31], pdx} - {e0x_reg[31], e0x_reg};
            end
            S_NAXIS:
            begin
                ndx = {bvx_reg[31], bvx_reg} - {cc_x[31], cc_x};
                ndy = {bvy_reg[31], bvy_reg} - {cc_y[31], cc_y};
            end
            S_NDIFF:
            begin
                ndx = {pdx[31], pdx} - {cc_x[31], cc_x};
                ndy = {pdy[31], pdy} - {cc_y[31], cc_y};
            end
            default:
            begin
                ndx = dcx;
                ndy = dcy;
            end
        endcase

        nreq.start = (state_reg == S_EW2) || (state_reg == S_NAXIS) ||
                     (state_reg == S_CC2 && cc_hit) || (state_reg == S_CC3 && nrsp.done);
        nreq.raw   = state_reg == S_CC2;
        nreq.dx    = ndx;
        nreq.dy    = ndy;
    end

    assign done              = done_reg;
    assign hit               = hit_reg;
    assign normal_x          = nx_reg;
    assign normal_y          = ny_reg;
    assign penetration_depth = depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= P_EDGE_A;
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            ca_x_reg   <= '0;
            ca_y_reg   <= '0;
            ra_reg     <= '0;
            circ_a_reg <= 1'b0;
            cb_x_reg   <= '0;
            cb_y_reg   <= '0;
            rb_reg     <= '0;
            circ_b_reg <= 1'b0;
            idx_reg    <= '0;
            pidx_reg   <= '0;
            addr_reg   <= '0;
            e0x_reg    <= '0;
            e0y_reg    <= '0;
            ax_reg     <= '0;
            ay_reg     <= '0;
            pxa_reg    <= '0;
            pya_reg    <= '0;
            pxb_reg    <= '0;
            pyb_reg    <= '0;
            loa_reg    <= '0;
            hia_reg    <= '0;
            lob_reg    <= '0;
            hib_reg    <= '0;
            best_reg   <= '1;
            bnx_reg    <= '0;
            bny_reg    <= '0;
            tested_reg <= 1'b0;
            bd_reg     <= '1;
            bvx_reg    <= '0;
            bvy_reg    <= '0;
            curx_reg   <= '0;
            cury_reg   <= '0;
            nmx_reg    <= '0;
            nmy_reg    <= '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
            rr_reg     <= '0;
            rsum_reg   <= '0;
            dpx_reg    <= '0;
            dpy_reg    <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            nx_reg     <= '0;
            ny_reg     <= '0;
            depth_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (opcode)
                            csct_pkg::OP_VERT_A:
                            begin
                                if (we_a)
                                begin
                                    cnt_a_reg <= cnt_a_reg + CW'(1);
                                end
                            end
                            csct_pkg::OP_VERT_B:
                            begin
                                if (we_b)
                                begin
                                    cnt_b_reg <= cnt_b_reg + CW'(1);
                                end
                            end
                            csct_pkg::OP_DESC_A:
                            begin
                                ca_x_reg   <= coord_x;
                                ca_y_reg   <= coord_y;
                                ra_reg     <= radius;
                                circ_a_reg <= is_circle;
                            end
                            default:
                            begin
                                cb_x_reg   <= coord_x;
                                cb_y_reg   <= coord_y;
                                rb_reg     <= radius;
                                circ_b_reg <= is_circle;
                                state_reg  <= S_CHECK;
                            end
                        endcase
                    end
                end
                S_CHECK:
                begin
                    best_reg   <= '1;
                    tested_reg <= 1'b0;
                    bnx_reg    <= '0;
                    bny_reg    <= '0;
                    idx_reg    <= '0;
                    if (circ_a_reg && circ_b_reg)
                    begin
                        state_reg <= S_CC0;
                    end
                    else if ((!circ_a_reg && cnt_a_reg == '0) ||
                             (!circ_b_reg && cnt_b_reg == '0))
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        phase_reg <= circ_a_reg ? P_EDGE_B : P_EDGE_A;
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    addr_reg  <= idx_reg[AW-1:0];
                    state_reg <= S_EW0;
                end
                S_EW0:
                begin
                    addr_reg  <= edge_j[AW-1:0];
                    state_reg <= S_EW1;
                end
                S_EW1:
                begin
                    e0x_reg   <= pdx;
                    e0y_reg   <= pdy;
                    state_reg <= S_EW2;
                end
                S_EW2:
                begin
                    state_reg <= S_NWAIT;
                end
                S_NWAIT:
                begin
                    if (nrsp.done)
                    begin
                        // A zero-length axis is skipped.
                        if (nrsp.ux == '0 && nrsp.uy == '0)
                        begin
                            state_reg <= S_ADV;
                        end
                        else
                        begin
                            ax_reg    <= nrsp.ux;
                            ay_reg    <= nrsp.uy;
                            pidx_reg  <= '0;
                            state_reg <= S_PADDR;
                        end
                    end
                end
                S_PADDR:
                begin
                    addr_reg  <= pidx_reg[AW-1:0];
                    state_reg <= S_PWAIT;
                end
                S_PWAIT:
                begin
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                begin
                    pxa_reg   <= xa_src * ax_reg;
                    pya_reg   <= ya_src * ay_reg;
                    pxb_reg   <= xb_src * ax_reg;
                    pyb_reg   <= yb_src * ay_reg;
                    state_reg <= S_PACC;
                end
                S_PACC:
                begin
                    if (pidx_reg == '0)
                    begin
                        loa_reg <= circ_a_reg ? p_a - rr_a : p_a;
                        hia_reg <= circ_a_reg ? p_a + rr_a : p_a;
                        lob_reg <= circ_b_reg ? p_b - rr_b : p_b;
                        hib_reg <= circ_b_reg ? p_b + rr_b : p_b;
                    end
                    else
                    begin
                        if (!circ_a_reg && pidx_reg < cnt_a_reg)
                        begin
                            if (p_a < loa_reg)
                            begin
                                loa_reg <= p_a;
                            end
                            if (p_a > hia_reg)
                            begin
                                hia_reg <= p_a;
                            end
                        end
                        if (!circ_b_reg && pidx_reg < cnt_b_reg)
                        begin
                            if (p_b < lob_reg)
                            begin
                                lob_reg <= p_b;
                            end
                            if (p_b > hib_reg)
                            begin
                                hib_reg <= p_b;
                            end
                        end
                    end
                    pidx_reg  <= pidx_inc;
                    state_reg <= (pidx_inc == plen) ? S_EVAL : S_PADDR;
                end
                S_EVAL:
                begin
                    if (sep)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        tested_reg <= 1'b1;
                        if (dmin_u < best_reg)
                        begin
                            best_reg <= dmin_u;
                            bnx_reg  <= ax_reg;
                            bny_reg  <= ay_reg;
                        end
                        state_reg <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    case (phase_reg)
                        P_EDGE_A,
                        P_EDGE_B:
                        begin
                            if (idx_inc != n_sel)
                            begin
                                idx_reg   <= idx_inc;
                                state_reg <= S_EDGE;
                            end
                            else if (phase_reg == P_EDGE_A && !circ_b_reg)
                            begin
                                phase_reg <= P_EDGE_B;
                                idx_reg   <= '0;
                                state_reg <= S_EDGE;
                            end
                            else if (circ_a_reg || circ_b_reg)
                            begin
                                phase_reg <= P_NEAR;
                                idx_reg   <= '0;
                                bd_reg    <= '1;
                                state_reg <= S_NADDR;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_NADDR:
                begin
                    addr_reg  <= idx_reg[AW-1:0];
                    state_reg <= S_NWT;
                end
                S_NWT:
                begin
                    state_reg <= S_NDIFF;
                end
                S_NDIFF:
                begin
                    curx_reg  <= pdx;
                    cury_reg  <= pdy;
                    nmx_reg   <= csct_pkg::mag33(ndx);
                    nmy_reg   <= csct_pkg::mag33(ndy);
                    state_reg <= S_NSQ;
                end
                S_NSQ:
                begin
                    s1_reg    <= nmx_reg * nmx_reg;
                    s2_reg    <= nmy_reg * nmy_reg;
                    state_reg <= S_NCMP;
                end
                S_NCMP:
                begin
                    // The first vertex is taken even when its distance saturates.
                    if (ns < bd_reg || idx_reg == '0)
                    begin
                        bd_reg  <= ns;
                        bvx_reg <= curx_reg;
                        bvy_reg <= cury_reg;
                    end
                    if (idx_inc == n_sel)
                    begin
                        state_reg <= S_NAXIS;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_NADDR;
                    end
                end
                S_NAXIS:
                begin
                    state_reg <= S_NWAIT;
                end
                S_FIN:
                begin
                    if (!tested_reg)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        dpx_reg   <= dcx * bnx_reg;
                        dpy_reg   <= dcy * bny_reg;
                        state_reg <= S_FLIP;
                    end
                end
                S_FLIP:
                begin
                    done_reg  <= 1'b1;
                    hit_reg   <= 1'b1;
                    nx_reg    <= dot[49] ? -bnx_reg : bnx_reg;
                    ny_reg    <= dot[49] ? -bny_reg : bny_reg;
                    depth_reg <= poly_depth;
                    cnt_a_reg <= '0;
                    cnt_b_reg <= '0;
                    state_reg <= S_IDLE;
                end
                S_CC0:
                begin
                    nmx_reg   <= csct_pkg::mag33(dcx);
                    nmy_reg   <= csct_pkg::mag33(dcy);
                    rsum_reg  <= {1'b0, ra_reg} + {1'b0, rb_reg};
                    state_reg <= S_CC1;
                end
                S_CC1:
                begin
                    s1_reg    <= nmx_reg * nmx_reg;
                    s2_reg    <= nmy_reg * nmy_reg;
                    rr_reg    <= rsum_reg * rsum_reg;
                    state_reg <= S_CC2;
                end
                S_CC2:
                begin
                    state_reg <= cc_hit ? S_CC3 : S_MISS;
                end
                S_CC3:
                begin
                    if (nrsp.done)
                    begin
                        depth_reg <= cc_dd[31] ? 31'h7FFF_FFFF : cc_dd[30:0];
                        state_reg <= S_CC4;
                    end
                end
                S_CC4:
                begin
                    if (nrsp.done)
                    begin
                        done_reg  <= 1'b1;
                        hit_reg   <= 1'b1;
                        nx_reg    <= nrsp.ux;
                        ny_reg    <= nrsp.uy;
                        cnt_a_reg <= '0;
                        cnt_b_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_MISS:
                begin
                    done_reg  <= 1'b1;
                    hit_reg   <= 1'b0;
                    nx_reg    <= '0;
                    ny_reg    <= '0;
                    depth_reg <= '0;
                    cnt_a_reg <= '0;
                    cnt_b_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a running test");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (normal_x == 16'sd0 && normal_y == 16'sd0 &&
                            penetration_depth == 31'd0))
        else $error("miss result carries nonzero normal or depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && cnt_a_reg == '0 && cnt_b_reg == '0))
        else $error("core not idle and cleared when result is shown");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CW'(MAX_VERTICES)) && (cnt_b_reg <= CW'(MAX_VERTICES)))
        else $error("vertex count beyond capacity");
`endif

endmodule

`default_nettype wire
